// ===== sv/dq_pkg.sv =====
// dq_pkg: types, codes and ring helpers shared by the double-ended queue core
// depends on nothing; imported by dq_front, dq_back, dq_result_queue and the top level
package dq_pkg;

  localparam int DEPTH     = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int CMD_DEPTH = 2;
  localparam int CPW       = $clog2(CMD_DEPTH);
  localparam int CCW       = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OPW       = $clog2(OUT_DEPTH);
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DRAIN      = 3'd4
  } op_t;

  localparam logic [1:0] ST_POPPED  = 2'd0;
  localparam logic [1:0] ST_DRAINED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic {
    SQ_IDLE,
    SQ_DRAIN
  } seq_state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic [1:0]         status;
    logic               last;
  } res_t;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
    logic [AW-1:0] res;
    if (base == '0) begin
      res = AW'(DEPTH - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== sv/double_ended_queue_core.sv =====
// double_ended_queue_core: top level of the bounded double-ended queue of 32-bit words
// depends on dq_pkg, dq_front, dq_back and dq_result_queue
//
// input channel: operation and value with push/full; a request is taken at a clock
//   edge with push high and full low. codes 0..4 push front, push back, pop front,
//   pop back, drain; other codes are taken and ignored
// result channel: word, status and last with empty/pop; the oldest result sits on
//   the ports while empty is low and leaves at an edge with pop high
// a pop result passes the command queue, the ring read register and the result queue; pushes give no
//   result unless the ring is full, then one result with status full
// pushes and pops run at one request per cycle while the result queue has room,
//   through the two-entry command queue; a drain holds the back end in its drain state,
//   one ring read per cycle with room, words front to back with last on the final one
// a stalled receiver fills the four-entry result queue, the back end then stops
//   issuing, the command queue fills and full rises; nothing is lost
// reset (synchronous, active high) empties every queue, sets head and fill to zero
//   and drops any request in flight; stored words stay undefined until written
module double_ended_queue_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] word,
  output logic [1:0]         status,
  output logic               last
);
  import dq_pkg::*;

  logic           cmd_valid;
  cmd_t           cmd;
  logic           cmd_take;
  logic [OCW-1:0] res_level;
  logic           res_wr;
  res_t           res_in;
  res_t           res_out;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .value     (value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  dq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_level (res_level),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  dq_result_queue u_result_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (res_wr),
    .wr_res (res_in),
    .pop    (pop),
    .empty  (empty),
    .rd_res (res_out),
    .level  (res_level)
  );

  assign word   = res_out.word;
  assign status = res_out.status;
  assign last   = res_out.last;

endmodule

// ===== sv/dq_front.sv =====
// dq_front: accepts input requests, drops unused operation codes and queues the rest
// depends on dq_pkg; feeds dq_back through a two-entry command queue
module dq_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  output logic               cmd_valid,
  output dq_pkg::cmd_t       cmd,
  input  logic               cmd_take
);
  import dq_pkg::*;

  cmd_t           q [CMD_DEPTH];
  logic [CPW-1:0] wptr;
  logic [CPW-1:0] rptr;
  logic [CCW-1:0] count;
  logic           accept;
  logic           enq;
  logic           deq;

  assign full      = (count == CCW'(CMD_DEPTH));
  assign accept    = push && !full;
  assign enq       = accept && (operation inside {[OP_PUSH_FRONT:OP_DRAIN]});
  assign cmd_valid = (count != '0);
  assign deq       = cmd_valid && cmd_take;
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wptr <= wptr + 1'b1;
      end
      if (deq) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CCW'(enq) - CCW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wptr].op    <= op_t'(operation);
      q[wptr].value <= value;
    end
  end

endmodule

// ===== sv/dq_result_queue.sv =====
// dq_result_queue: small result queue that parts the back end from the receiver
// depends on dq_pkg; written by dq_back, read through the top-level result ports
module dq_result_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr,
  input  dq_pkg::res_t           wr_res,
  input  logic                   pop,
  output logic                   empty,
  output dq_pkg::res_t           rd_res,
  output logic [dq_pkg::OCW-1:0] level
);
  import dq_pkg::*;

  res_t           q [OUT_DEPTH];
  logic [OPW-1:0] wptr;
  logic [OPW-1:0] rptr;
  logic [OCW-1:0] count;
  logic           deq;

  assign empty  = (count == '0);
  assign deq    = pop && !empty;
  assign rd_res = q[rptr];
  assign level  = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (deq) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + OCW'(wr) - OCW'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wptr] <= wr_res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= OCW'(OUT_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (count < OCW'(OUT_DEPTH)))
    else $error("result written while queue full");

  a_pop_drops: assert property (@(posedge clk) disable iff (rst)
    (deq && !wr) |=> (count == $past(count) - 1'b1))
    else $error("result queue count not reduced on pop");

endmodule

// ===== sv/dq_back.sv =====
// dq_back: ring store, head index and fill count, and the drain sequencer
// depends on dq_pkg; takes commands from dq_front and writes dq_result_queue
module dq_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  dq_pkg::cmd_t           cmd,
  output logic                   cmd_take,
  input  logic [dq_pkg::OCW-1:0] res_level,
  output logic                   res_wr,
  output dq_pkg::res_t           res
);
  import dq_pkg::*;

  logic signed [31:0] mem [DEPTH];
  seq_state_t         state;
  seq_state_t         state_next;
  logic [AW-1:0]      head;
  logic [AW-1:0]      head_next;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_next;
  logic [CW-1:0]      fill_m1;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      idx_next;
  logic               room;
  logic               drain_last;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               iss;
  logic               iss_zero;
  logic [1:0]         iss_status;
  logic               iss_last;
  logic               rd_pend;
  logic               rd_zero;
  logic [1:0]         rd_status;
  logic               rd_last;
  logic signed [31:0] rd_data;

  assign fill_m1    = fill - 1'b1;
  assign room       = ({1'b0, res_level} + (OCW+1)'(rd_pend)) < (OCW+1)'(OUT_DEPTH);
  assign drain_last = (idx == fill_m1[AW-1:0]);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (cmd_valid && room && cmd.op == OP_DRAIN && fill != '0) begin
          state_next = SQ_DRAIN;
        end
      end
      SQ_DRAIN: begin
        if (room && drain_last) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cmd_take   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head;
    rd_en      = 1'b0;
    rd_addr    = head;
    iss        = 1'b0;
    iss_zero   = 1'b0;
    iss_status = ST_POPPED;
    iss_last   = 1'b1;
    head_next  = head;
    fill_next  = fill;
    idx_next   = idx;
    case (state)
      SQ_IDLE: begin
        if (cmd_valid && room) begin
          cmd_take = 1'b1;
          case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (fill == CW'(DEPTH)) begin
                iss        = 1'b1;
                iss_zero   = 1'b1;
                iss_status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                fill_next = fill + 1'b1;
                if (cmd.op == OP_PUSH_FRONT) begin
                  wr_addr   = ring_dec(head);
                  head_next = ring_dec(head);
                end else begin
                  wr_addr = ring_add(head, fill[AW-1:0]);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (fill != '0) begin
                rd_en     = 1'b1;
                iss       = 1'b1;
                fill_next = fill_m1;
                if (cmd.op == OP_POP_FRONT) begin
                  head_next = ring_add(head, AW'(1));
                end else begin
                  rd_addr = ring_add(head, fill_m1[AW-1:0]);
                end
              end
            end
            OP_DRAIN: begin
              idx_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      SQ_DRAIN: begin
        if (room) begin
          rd_en      = 1'b1;
          rd_addr    = ring_add(head, idx);
          iss        = 1'b1;
          iss_status = ST_DRAINED;
          iss_last   = drain_last;
          if (drain_last) begin
            fill_next = '0;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SQ_IDLE;
      head    <= '0;
      fill    <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      fill    <= fill_next;
      idx     <= idx_next;
      rd_pend <= iss;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (iss) begin
      rd_zero   <= iss_zero;
      rd_status <= iss_status;
      rd_last   <= iss_last;
    end
  end

  assign res_wr     = rd_pend;
  assign res.word   = rd_zero ? 32'sd0 : rd_data;
  assign res.status = rd_status;
  assign res.last   = rd_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == SQ_DRAIN) |-> (fill != '0))
    else $error("drain running on an empty ring");

  a_pend_room: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (res_level < OCW'(OUT_DEPTH)))
    else $error("result issued without space in result queue");

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for double_ended_queue_core, push/full in, empty/pop out
// depends on dq_pkg and double_ended_queue_core; a scoreboard class predicts every result
`timescale 1ns / 100ps

module tb_top;
  import dq_pkg::*;

  class dq_scoreboard;
    logic signed [31:0] ring [DEPTH];
    int unsigned        head;
    logic [CW-1:0]      fill;
    res_t               expected [$];
    int                 errors;
    int                 requests;
    int                 checked;
    int                 drains;
    int                 rejects;

    function new();
      head     = 0;
      fill     = '0;
      errors   = 0;
      requests = 0;
      checked  = 0;
      drains   = 0;
      rejects  = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_request(input logic [2:0] op, input logic signed [31:0] val);
      res_t        r;
      int unsigned idx;
      int unsigned i;
      requests++;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill == DEPTH) begin
            r.word   = '0;
            r.status = ST_FULL;
            r.last   = 1'b1;
            expected.push_back(r);
            rejects++;
          end else begin
            if (op == OP_PUSH_FRONT) begin
              head       = (head + DEPTH - 1) % DEPTH;
              ring[head] = val;
            end else begin
              ring[(head + fill) % DEPTH] = val;
            end
            fill++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (fill != 0) begin
            if (op == OP_POP_FRONT) begin
              idx  = head;
              head = (head + 1) % DEPTH;
            end else begin
              idx = (head + fill - 1) % DEPTH;
            end
            fill--;
            r.word   = ring[idx];
            r.status = ST_POPPED;
            r.last   = 1'b1;
            expected.push_back(r);
          end
        end
        OP_DRAIN: begin
          if (fill != 0) begin
            drains++;
          end
          for (i = 0; i < fill; i++) begin
            r.word   = ring[(head + i) % DEPTH];
            r.status = ST_DRAINED;
            r.last   = (i + 1 == fill);
            expected.push_back(r);
          end
          fill = '0;
        end
        default: begin
        end
      endcase
    endfunction

    task check_result(input logic signed [31:0] w, input logic [1:0] st, input logic lst);
      res_t e;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("result word %0d status %0d with nothing expected", w, st));
      end else begin
        e = expected.pop_front();
        checked++;
        if (w !== e.word) begin
          report_mismatch($sformatf("word %0d, expected %0d", w, e.word));
        end
        if (st !== e.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
        end
        if (lst !== e.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", lst, e.last));
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst       = 1'b1;
  logic               push      = 1'b0;
  logic               full;
  logic [2:0]         operation = '0;
  logic signed [31:0] value     = '0;
  logic               empty;
  logic               pop       = 1'b0;
  logic signed [31:0] word;
  logic [1:0]         status;
  logic               last;

  int send_idle  = 0;
  int recv_stall = 0;

  dq_scoreboard sb = new();

  double_ended_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .word      (word),
    .status    (status),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      sb.note_request(operation, value);
    end
    if (!rst && pop && !empty) begin
      sb.check_result(word, status, last);
    end
  end

  task automatic send_request(input logic [2:0] op, input logic signed [31:0] val);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    operation <= op;
    value     <= val;
    push      <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic settle(input int extra);
    push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    logic signed [31:0] w;
    case ($urandom_range(7))
      0:       w = 32'sh7fff_ffff;
      1:       w = 32'sh8000_0000;
      2:       w = '0;
      3:       w = -32'sd1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] rand_push();
    return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] rand_pop();
    return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
  endfunction

  initial begin
    int          phase;
    int          count;
    int          n;
    int unsigned r;
    logic [2:0]  op;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue corners, unused codes and short push, pop and drain sequences
    send_request(OP_POP_FRONT, 32'sd17);
    send_request(OP_POP_BACK, -32'sd17);
    send_request(OP_DRAIN, '0);
    send_request(3'd5, 32'sh7fff_ffff);
    send_request(3'd6, 32'sh8000_0000);
    send_request(3'd7, -32'sd1);
    send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_request(OP_PUSH_BACK, 32'sh8000_0000);
    send_request(OP_PUSH_FRONT, '0);
    send_request(OP_PUSH_FRONT, -32'sd1);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_BACK, '0);
    send_request(OP_PUSH_FRONT, 32'sd1);
    send_request(OP_PUSH_BACK, 32'sh5555_5555);
    send_request(OP_PUSH_FRONT, 32'shaaaa_aaaa);
    send_request(OP_DRAIN, '0);
    send_request(OP_PUSH_BACK, 32'sd42);
    send_request(OP_POP_BACK, '0);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_DRAIN, '0);
    send_request(OP_PUSH_FRONT, -32'sd42);
    send_request(OP_DRAIN, '0);
    settle(8);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 50;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 50;
        end
        default: begin
          send_idle  = 34;
          recv_stall = 34;
        end
      endcase
      count = 0;

      // fill to capacity, then a few refused requests; odd phases pop down to half; every phase then drains
      while (sb.fill < DEPTH) begin
        send_request(rand_push(), rand_word());
        count++;
      end
      n = $urandom_range(4, 1);
      repeat (n) begin
        send_request(rand_push(), rand_word());
        count++;
      end
      if (phase % 2 == 1) begin
        while (sb.fill > DEPTH / 2) begin
          send_request(rand_pop(), rand_word());
          count++;
        end
      end
      send_request(OP_DRAIN, rand_word());
      count++;

      while (count < 76) begin
        r = $urandom_range(99);
        if (r < 4) begin
          op = 3'(5 + $urandom_range(2));
        end else if (r < 10) begin
          op = OP_DRAIN;
        end else if (r < 58) begin
          op = rand_push();
        end else begin
          op = rand_pop();
        end
        send_request(op, rand_word());
        if (op <= OP_DRAIN) begin
          count++;
        end
      end

      // sender holds off until every outstanding result is back
      settle(8);
    end

    settle(20);
    $display("ran %0d requests over four idling patterns, %0d results checked",
             sb.requests, sb.checked);
    $display("%0d non-empty drains and %0d refused pushes on a full queue",
             sb.drains, sb.rejects);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
